[design/rbf_pkg.sv]
package rbf_pkg;

   // Fixed field widths of the ports.
   localparam int PIXEL_W    = 16;
   localparam int RADIUS_W   = 4;
   localparam int SCALE_W    = 17;
   localparam int OUT_W      = 21;
   localparam int POS_W      = 16;
   localparam int FRAC_W     = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 17;

   // Register map of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIUS = 1'b0,
      CSR_SCALE  = 1'b1
   } csr_index_type;

   // Reset values and limits.
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 4'd1;
   localparam logic [SCALE_W-1:0]  SCALE_RESET  = 17'h10000;
   localparam logic [OUT_W-1:0]    OUT_MAX      = '1;
   localparam logic [POS_W-1:0]    POS_MAX      = '1;

endpackage

[design/rbf_ram.sv]
module rbf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/row_box_filter_replicate_unit.sv]
// Horizontal box filter over one image row with replicated borders. The block takes one
// pixel per clock while req_ready is high and keeps a running window sum; result k leaves
// once pixel k+R has arrived, scaled by the Q1.16 scale and rounded down, saturating at 21
// bits. The flagged last pixel of a row yields all results still owed: R+1 of them, or all
// n on a row of n <= R pixels. It is accepted like any other pixel, and req_ready then stays
// low while the drain sequencer issues the remaining R results (n-1 on such a short row),
// one result per cycle while the skid stage is free, since each needs one read of the
// history RAM and one pass through the single running-sum adder. A result passes the sum
// stage and the scale stage before it is loaded into the output register: the history read
// goes out with the request, then come the sum update and the scale multiply. When the
// result channel stalls and the skid stage behind the output register fills, req_ready
// also drops until a result is taken. The radius is sampled at the first pixel of each row.
// History lives in a RAM of 2**clog2(2*MAX_RADIUS+2) entries used as a circular buffer;
// it needs no clearing pass.
module row_box_filter_replicate_unit #(
   parameter int MAX_RADIUS  = 15,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel.
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [rbf_pkg::PIXEL_W-1:0]      req_pixel,
   input  logic                             req_last_in_row,
   // Result channel.
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [rbf_pkg::OUT_W-1:0]        rsp_filtered,
   output logic                             rsp_row_end,
   // Configuration port.
   input  logic                             csr_wr_en,
   input  logic [rbf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rbf_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import rbf_pkg::*;

   localparam int R_W    = $clog2(MAX_RADIUS + 1);
   localparam int D_W    = $clog2(2 * MAX_RADIUS + 2);
   localparam int DEPTH  = 1 << D_W;
   localparam int SUM_W  = SAMPLE_BITS + D_W;
   localparam int PROD_W = SUM_W + SCALE_W;
   localparam int HI_W   = PROD_W - FRAC_W;
   localparam int CMP_W  = HI_W + OUT_W;

   // Configuration registers.
   logic [RADIUS_W-1:0]    radius_ff, radius_in;
   logic [SCALE_W-1:0]     scale_ff, scale_in;

   // Row control.
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [R_W-1:0]         row_r_ff, row_r_in;
   logic [SAMPLE_BITS-1:0] first_ff, first_in;
   logic [D_W-1:0]         wptr_ff, wptr_in;

   // Drain sequencer.
   logic                   drain_ff, drain_in;
   logic [D_W-1:0]         drain_d_ff, drain_d_in;
   logic [SAMPLE_BITS-1:0] drain_px_ff, drain_px_in;
   logic [POS_W-1:0]       drain_pos_ff, drain_pos_in;

   // Sum stage.
   logic                   s1_vld_ff, s1_base_zero_ff, s1_sub_ff, s1_first_ff;
   logic                   s1_emit_ff, s1_end_ff;
   logic [SUM_W-1:0]       s1_add_ff;
   logic [SUM_W-1:0]       sum_ff, sum_in;

   // Scale stage.
   logic                   s2_vld_ff, s2_end_ff;
   logic [SUM_W-1:0]       s2_sum_ff;

   // Output register and skid stage.
   logic                   out_vld_ff, out_vld_in;
   logic [OUT_W-1:0]       out_filt_ff, out_filt_in;
   logic                   out_end_ff, out_end_in;
   logic                   skid_vld_ff, skid_vld_in;
   logic [OUT_W-1:0]       skid_filt_ff, skid_filt_in;
   logic                   skid_end_ff, skid_end_in;

   // Combinational signals.
   logic                   advance, accept, row_start, short_last, start_drain;
   logic [SAMPLE_BITS-1:0] sample;
   logic [R_W-1:0]         r_cfg, r_cur;
   logic [POS_W-1:0]       r_pos;
   logic [D_W-1:0]         win, factor, drain_start_d;
   logic                   drain_end, drain_use_first;
   logic                   op_vld, op_base_zero, op_sub, op_first, op_emit, op_end;
   logic [SUM_W-1:0]       op_add;
   logic [D_W-1:0]         rd_addr;
   logic [SAMPLE_BITS-1:0] ram_rd_data;
   logic [SUM_W-1:0]       sum_base, sum_leave, sum_next;
   logic [PROD_W-1:0]      scaled_prod;
   logic [HI_W-1:0]        scaled_hi;
   logic [OUT_W-1:0]       push_filt;
   logic                   push;

   // The pipeline moves whenever the skid stage is free.
   assign advance   = !skid_vld_ff;
   assign req_ready = advance && !drain_ff;
   assign accept    = req_valid && req_ready;

   assign sample    = SAMPLE_BITS'(req_pixel);
   assign row_start = (pos_ff == '0);
   assign r_cfg     = (32'(radius_ff) > MAX_RADIUS) ? R_W'(MAX_RADIUS) : R_W'(radius_ff);
   assign r_cur     = row_start ? r_cfg : row_r_ff;
   assign r_pos     = POS_W'(r_cur);
   assign win       = D_W'({r_cur, 1'b1});
   assign short_last = req_last_in_row && (pos_ff < r_pos);

   // Weight of the entering pixel: R+1 when the window opens, plus the replicated
   // right border when a short row ends before the window is full.
   always_comb begin
      factor = row_start ? (D_W'(r_cur) + D_W'(1)) : D_W'(1);
      if (short_last) begin
         factor = factor + D_W'(r_pos - pos_ff);
      end
   end

   // Drain length and first look-back distance after the last pixel.
   assign drain_start_d = short_last ? D_W'(pos_ff + r_pos) : D_W'({r_cur, 1'b0});
   assign start_drain   = req_last_in_row && (short_last ? (pos_ff != '0) : (r_cur != '0));
   assign drain_end       = (drain_d_ff == (D_W'(row_r_ff) + D_W'(1)));
   assign drain_use_first = (POS_W'(drain_d_ff) > drain_pos_ff);

   // Select the operation issued to the sum stage this cycle.
   always_comb begin
      op_vld       = 1'b0;
      op_base_zero = 1'b0;
      op_add       = '0;
      op_sub       = 1'b0;
      op_first     = 1'b0;
      op_emit      = 1'b0;
      op_end       = 1'b0;
      rd_addr      = wptr_ff - win;
      if (drain_ff) begin
         op_vld   = 1'b1;
         op_add   = SUM_W'(drain_px_ff);
         op_sub   = 1'b1;
         op_first = drain_use_first;
         op_emit  = 1'b1;
         op_end   = drain_end;
         rd_addr  = wptr_ff - drain_d_ff - D_W'(1);
      end else begin
         op_vld       = accept;
         op_base_zero = row_start;
         op_add       = SUM_W'(sample) * SUM_W'(factor);
         op_sub       = (pos_ff > r_pos);
         op_first     = (POS_W'(win) > pos_ff);
         op_emit      = (pos_ff >= r_pos) || req_last_in_row;
         op_end       = req_last_in_row && ((r_cur == '0) || row_start);
      end
   end

   // Sample history.
   rbf_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wptr_ff),
      .wr_data (sample),
      .rd_en   (advance),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // Configuration writes.
   always_comb begin
      radius_in = radius_ff;
      scale_in  = scale_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_RADIUS: radius_in = RADIUS_W'(csr_wdata);
            CSR_SCALE:  scale_in  = SCALE_W'(csr_wdata);
            default:    radius_in = radius_ff;
         endcase
      end
   end

   // Row position, first pixel, row radius and write pointer.
   always_comb begin
      pos_in   = pos_ff;
      row_r_in = row_r_ff;
      first_in = first_ff;
      wptr_in  = wptr_ff;
      if (accept) begin
         wptr_in = wptr_ff + D_W'(1);
         if (row_start) begin
            row_r_in = r_cfg;
            first_in = sample;
         end
         if (req_last_in_row) begin
            pos_in = '0;
         end else if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   // Drain sequencer: walks the look-back distance down to R+1.
   always_comb begin
      drain_in     = drain_ff;
      drain_d_in   = drain_d_ff;
      drain_px_in  = drain_px_ff;
      drain_pos_in = drain_pos_ff;
      if (advance && drain_ff) begin
         drain_d_in = drain_d_ff - D_W'(1);
         if (drain_end) begin
            drain_in = 1'b0;
         end
      end
      if (accept && start_drain) begin
         drain_in     = 1'b1;
         drain_d_in   = drain_start_d;
         drain_px_in  = sample;
         drain_pos_in = pos_ff;
      end
   end

   // Running sum update.
   always_comb begin
      sum_base  = s1_base_zero_ff ? '0 : sum_ff;
      sum_leave = '0;
      if (s1_sub_ff) begin
         sum_leave = s1_first_ff ? SUM_W'(first_ff) : SUM_W'(ram_rd_data);
      end
      sum_next = sum_base + s1_add_ff - sum_leave;
      sum_in   = (advance && s1_vld_ff) ? sum_next : sum_ff;
   end

   // Scale multiply with saturation.
   assign scaled_prod = PROD_W'(s2_sum_ff) * PROD_W'(scale_ff);
   assign scaled_hi   = scaled_prod[PROD_W-1:FRAC_W];
   assign push_filt   = (CMP_W'(scaled_hi) > CMP_W'(OUT_MAX)) ? OUT_MAX : OUT_W'(scaled_hi);
   assign push        = advance && s2_vld_ff;

   // Output register with skid stage.
   always_comb begin
      out_vld_in   = out_vld_ff;
      out_filt_in  = out_filt_ff;
      out_end_in   = out_end_ff;
      skid_vld_in  = skid_vld_ff;
      skid_filt_in = skid_filt_ff;
      skid_end_in  = skid_end_ff;
      if (!out_vld_ff || rsp_ready) begin
         if (skid_vld_ff) begin
            out_vld_in  = 1'b1;
            out_filt_in = skid_filt_ff;
            out_end_in  = skid_end_ff;
            skid_vld_in = 1'b0;
         end else begin
            out_vld_in  = push;
            out_filt_in = push_filt;
            out_end_in  = s2_end_ff;
         end
      end else if (push) begin
         skid_vld_in  = 1'b1;
         skid_filt_in = push_filt;
         skid_end_in  = s2_end_ff;
      end
   end

   assign rsp_valid    = out_vld_ff;
   assign rsp_filtered = out_filt_ff;
   assign rsp_row_end  = out_end_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff   <= RADIUS_RESET;
         scale_ff    <= SCALE_RESET;
         pos_ff      <= '0;
         row_r_ff    <= R_W'(1);
         first_ff    <= '0;
         wptr_ff     <= '0;
         drain_ff    <= 1'b0;
         sum_ff      <= '0;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         radius_ff   <= radius_in;
         scale_ff    <= scale_in;
         pos_ff      <= pos_in;
         row_r_ff    <= row_r_in;
         first_ff    <= first_in;
         wptr_ff     <= wptr_in;
         drain_ff    <= drain_in;
         sum_ff      <= sum_in;
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
         if (advance) begin
            s1_vld_ff <= op_vld;
            s2_vld_ff <= s1_vld_ff && s1_emit_ff;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      drain_d_ff   <= drain_d_in;
      drain_px_ff  <= drain_px_in;
      drain_pos_ff <= drain_pos_in;
      out_filt_ff  <= out_filt_in;
      out_end_ff   <= out_end_in;
      skid_filt_ff <= skid_filt_in;
      skid_end_ff  <= skid_end_in;
      if (advance) begin
         s1_base_zero_ff <= op_base_zero;
         s1_add_ff       <= op_add;
         s1_sub_ff       <= op_sub;
         s1_first_ff     <= op_first;
         s1_emit_ff      <= op_emit;
         s1_end_ff       <= op_end;
         s2_sum_ff       <= sum_next;
         s2_end_ff       <= s1_end_ff;
      end
   end

   // The skid stage only fills behind a stalled output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid stage holds a result while the output register is empty");

   // While draining, the look-back distance never falls below R+1.
   a_drain_distance: assert property (@(posedge clock) disable iff (reset)
      drain_ff |-> (drain_d_ff > D_W'(row_r_ff)))
      else $error("drain look-back distance ran past the window");

   // The drain stops right after its final result is issued.
   a_drain_stops: assert property (@(posedge clock) disable iff (reset)
      drain_ff && advance && drain_end |=> !drain_ff)
      else $error("drain continued after the row end result");

endmodule

[tb/testbench.sv]
module testbench;
   import rbf_pkg::*;

   localparam int ROW_RADIUS_MAX = 15;
   localparam int HISTORY_DEPTH  = 2 * ROW_RADIUS_MAX + 1;
   localparam int TARGET_ITEMS   = 430;
   localparam int CALM_FROM      = 370;

   typedef struct packed {
      logic [OUT_W-1:0] filtered;
      logic             row_end;
   } filtered_pixel_type;

   // Tracks the row filter: settings, history and running sum, and the results still owed.
   class box_filter_scoreboard;
      logic [RADIUS_W-1:0] radius_reg;
      logic [SCALE_W-1:0]  scale_reg;
      logic [PIXEL_W-1:0]  history [HISTORY_DEPTH];
      logic [PIXEL_W-1:0]  row_first;
      longint unsigned     window_total;
      int                  row_pos;
      int                  row_radius;
      filtered_pixel_type  owed_q[$];
      int                  error_count;
      int                  request_count;
      int                  result_count;

      function new();
         radius_reg   = RADIUS_RESET;
         scale_reg    = SCALE_RESET;
         row_first    = '0;
         window_total = 0;
         row_pos      = 0;
         row_radius   = 1;
         foreach (history[i]) history[i] = '0;
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_RADIUS: begin
               radius_reg = data[RADIUS_W-1:0];
            end
            CSR_SCALE: begin
               scale_reg = data[SCALE_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      // Sample d places behind the newest one; the first pixel stands in before the row.
      function longint unsigned sample_back(int d, int newest);
         if (d > newest || d < 0 || d >= HISTORY_DEPTH)
            return row_first;
         return history[d];
      endfunction

      // Scale the current window sum and queue it as the next result.
      function void owe_result(logic end_flag);
         longint unsigned v;
         filtered_pixel_type item;
         v = (window_total * scale_reg) >> FRAC_W;
         if (v > OUT_MAX)
            v = OUT_MAX;
         item.filtered = v[OUT_W-1:0];
         item.row_end  = end_flag;
         owed_q.push_back(item);
      endfunction

      function void note_request(logic [PIXEL_W-1:0] pix, logic last);
         int pos;
         int r;
         int k;
         int idx;
         longint unsigned leave;
         request_count++;
         pos = row_pos;

         // The window opens on the first pixel, weighted r+1; later pixels slide it.
         if (pos == 0) begin
            row_radius   = (radius_reg > ROW_RADIUS_MAX) ? ROW_RADIUS_MAX : int'(radius_reg);
            row_first    = pix;
            window_total = pix;
            window_total = window_total * (row_radius + 1);
         end else begin
            window_total += pix;
            if (pos > row_radius)
               window_total -= sample_back(2 * row_radius, pos - 1);
         end
         r = row_radius;

         for (int i = HISTORY_DEPTH - 1; i > 0; i--)
            history[i] = history[i - 1];
         history[0] = pix;

         if (pos >= r)
            owe_result(last && r == 0);

         // The last pixel drains the remaining outputs, replicating itself on the right.
         if (last) begin
            if (pos < r) begin
               window_total += pix * (r - pos);
               owe_result(pos == 0);
               k = 1;
            end else begin
               k = pos - r + 1;
            end
            while (k <= pos) begin
               idx = k - 1 - r;
               leave = (idx < 0) ? longint'(row_first) : sample_back(pos - idx, pos);
               window_total += pix;
               window_total -= leave;
               owe_result(k == pos);
               k++;
            end
            row_pos      = 0;
            window_total = 0;
         end else if (row_pos < POS_MAX) begin
            row_pos++;
         end
      endfunction

      function void check_result(logic [OUT_W-1:0] filt, logic end_flag);
         filtered_pixel_type want;
         result_count++;
         if (owed_q.size() == 0) begin
            $error("unexpected result: filtered %0d, row_end %0d", filt, end_flag);
            error_count++;
            return;
         end
         want = owed_q.pop_front();
         if (filt !== want.filtered) begin
            $error("filtered: expected %0d, actual %0d", want.filtered, filt);
            error_count++;
         end
         if (end_flag !== want.row_end) begin
            $error("row_end: expected %0d, actual %0d", want.row_end, end_flag);
            error_count++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [PIXEL_W-1:0]    req_pixel;
   logic                  req_last_in_row;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [OUT_W-1:0]      rsp_filtered;
   logic                  rsp_row_end;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   box_filter_scoreboard sb = new();

   bit valid_held;
   bit calm;
   int idle_odds;
   int sent_count;
   int settings_count;

   row_box_filter_replicate_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel       (req_pixel),
      .req_last_in_row (req_last_in_row),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_filtered    (rsp_filtered),
      .rsp_row_end     (rsp_row_end),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Note every accepted request before checking the result of the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_pixel, req_last_in_row);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_filtered, rsp_row_end);
      end
   end

   // Result side: random stall bursts, none once the run turns calm.
   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin
      #60000000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic logic [PIXEL_W-1:0] pick_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return PIXEL_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Hold one request until accepted, then maybe leave a gap.
   task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input logic last);
      req_valid       <= 1'b1;
      req_pixel       <= pix;
      req_last_in_row <= last;
      valid_held = 1'b1;
      do @(posedge clock); while (!req_ready);
      sent_count++;
      if (!calm && $urandom_range(0, 3) < idle_odds) begin
         req_valid <= 1'b0;
         valid_held = 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic send_row(input int len);
      for (int i = 0; i < len; i++)
         send_pixel(pick_pixel(), i == len - 1);
   endtask

   // Let every owed result arrive, then give the pipeline time to empty.
   task automatic settle();
      if (valid_held) begin
         req_valid <= 1'b0;
         valid_held = 1'b0;
      end
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write radius then scale; junk above the radius field must be ignored.
   task automatic apply_settings(input int r, input int s);
      logic [CSR_DATA_W-1:0] w;
      w = CSR_DATA_W'($urandom);
      w[RADIUS_W-1:0] = RADIUS_W'(r);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_RADIUS;
      csr_wdata <= w;
      sb.write_register(CSR_RADIUS, w);
      @(posedge clock);
      csr_index <= CSR_SCALE;
      csr_wdata <= CSR_DATA_W'(s);
      sb.write_register(CSR_SCALE, CSR_DATA_W'(s));
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      settings_count++;
   endtask

   initial begin
      int r;
      int s;
      int len;
      int rows;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_pixel       <= '0;
      req_last_in_row <= 1'b0;
      csr_wr_en       <= 1'b0;
      csr_index       <= CSR_RADIUS;
      csr_wdata       <= '0;
      idle_odds = 1;
      settings_count = 1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed rows at the reset settings: a one-pixel row, a two-pixel row, extremes.
      send_pixel(16'hFFFF, 1'b1);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'hFFFF, 1'b1);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'h0001, 1'b0);
      send_pixel(16'h8000, 1'b1);
      settle();

      // A window of one pixel.
      apply_settings(0, 65536);
      send_pixel(16'h0007, 1'b0);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'h0000, 1'b1);
      settle();

      // Widest window on a short row of bright pixels, with the largest scale saturating.
      apply_settings(15, 131071);
      repeat (3) send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'hFFFF, 1'b1);
      settle();

      // Radius rewritten mid-row only applies from the next row on.
      apply_settings(2, 0);
      send_pixel(16'h1234, 1'b0);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'h0042, 1'b0);
      settle();
      apply_settings(5, 65536 / 11);
      send_pixel(16'hABCD, 1'b0);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'hFFFF, 1'b1);
      settle();

      // Random phases: new settings, then a few rows, mostly full length.
      while (sent_count < TARGET_ITEMS) begin
         if (sent_count >= CALM_FROM)
            calm = 1'b1;
         case ($urandom_range(0, 5))
            0: r = 0;
            1: r = 15;
            2: r = $urandom_range(0, 15);
            default: r = $urandom_range(1, 6);
         endcase
         case ($urandom_range(0, 5))
            0: s = 0;
            1: s = 65536;
            2: s = 131071;
            3: s = 65536 / (2 * r + 1) + $urandom_range(0, 1);
            default: s = $urandom_range(0, 131071);
         endcase
         apply_settings(r, s);
         idle_odds = $urandom_range(0, 3);
         rows = $urandom_range(1, 4);
         repeat (rows) begin
            if ($urandom_range(0, 5) == 0)
               len = $urandom_range(1, 2 * r + 1);
            else
               len = $urandom_range(2 * r + 1, 2 * r + 24);
            send_row(len);
         end
         settle();
      end

      $display("Checked %0d filtered results from %0d pixel requests over %0d settings.",
               sb.result_count, sb.request_count, settings_count);
      $display("Rows covered radius 0 to 15, short rows, mid-row radius writes and saturating scales.");
      if (sb.error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
